// ----- design/tbc_pkg.sv -----
package tbc_pkg;

   localparam int CoordW  = 16;
   localparam int EdgeW   = CoordW + 1;
   localparam int ProdW   = 2 * EdgeW;
   localparam int DotW    = ProdW + 2;
   localparam int WideW   = 2 * DotW;
   localparam int DenW    = WideW - 2;
   localparam int RemW    = DenW + 1;
   localparam int QuotW   = 32;
   localparam int FracW   = 16;
   localparam int DivSteps = QuotW;

   localparam logic signed [QuotW-1:0] WeightMax = {1'b0, {(QuotW-1){1'b1}}};
   localparam logic signed [QuotW-1:0] WeightMin = {1'b1, {(QuotW-1){1'b0}}};
   localparam logic signed [QuotW+1:0] WeightOne = 34'sd65536;

   // One quotient lane of the long division: partial remainder, the word that
   // shifts dividend bits out and quotient bits in, and the sign and overflow
   // decided before the division started.
   typedef struct packed {
      logic [RemW-1:0]  rem;
      logic [QuotW-1:0] sh;
      logic             ovf;
      logic             neg;
   } div_lane_type;

   typedef struct packed {
      div_lane_type    lane_v;
      div_lane_type    lane_w;
      logic [DenW-1:0] den;
      logic            degen;
   } div_word_type;

endpackage

// ----- design/tbc_div_stage.sv -----
module tbc_div_stage import tbc_pkg::*; (
   input  logic         clock,
   input  logic         en,
   input  div_word_type d_in,
   output div_word_type d_ff
);

   div_word_type d_in_next;

   function automatic div_lane_type step(input div_lane_type l, input logic [DenW-1:0] den);
      logic [RemW-1:0] t;
      logic [RemW-1:0] dz;
      logic            take;
      div_lane_type    r;
      t    = {l.rem[RemW-2:0], l.sh[QuotW-1]};
      dz   = {1'b0, den};
      take = (t >= dz);
      r     = l;
      r.rem = take ? (t - dz) : t;
      r.sh  = {l.sh[QuotW-2:0], take};
      return r;
   endfunction

   always_comb begin
      d_in_next        = d_in;
      d_in_next.lane_v = step(d_in.lane_v, d_in.den);
      d_in_next.lane_w = step(d_in.lane_w, d_in.den);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         d_ff <= d_in_next;
      end
   end

endmodule

// ----- design/triangle_barycentric_coords.sv -----
// Barycentric weights of a point p against a triangle a, b, c, all in signed
// Q8.8. Each word yields one result word: weights u, v, w in signed Q15.16,
// rounded toward zero and saturated, and a degenerate flag that is set, with
// all weights zero, when the triangle has zero area. The block is a fully
// pipelined datapath of 41 register stages: seven stages form the edge
// vectors, dot products and the exact Cramer determinant and numerators,
// 32 stages each retire one quotient bit of the v and w divisions, and two
// stages saturate and form u. A new word is taken every cycle when the output
// side keeps up. Every stage stalls only when it holds a word and the stage
// after it cannot take one, so bubbles are squeezed out and a held result
// does not stop the input until the whole pipeline is full.
module triangle_barycentric_coords import tbc_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic signed [15:0] req_p_x,
   input  logic signed [15:0] req_p_y,
   input  logic signed [15:0] req_p_z,
   input  logic signed [15:0] req_a_x,
   input  logic signed [15:0] req_a_y,
   input  logic signed [15:0] req_a_z,
   input  logic signed [15:0] req_b_x,
   input  logic signed [15:0] req_b_y,
   input  logic signed [15:0] req_b_z,
   input  logic signed [15:0] req_c_x,
   input  logic signed [15:0] req_c_y,
   input  logic signed [15:0] req_c_z,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [31:0] rsp_weight_u,
   output logic signed [31:0] rsp_weight_v,
   output logic signed [31:0] rsp_weight_w,
   output logic               rsp_degenerate
);

   localparam int FrontStages = 7;
   localparam int NumStages   = FrontStages + DivSteps + 2;

   // Valid bits of every stage and the per-stage advance enables.
   logic [NumStages-1:0] vld_ff;
   logic [NumStages-1:0] en;

   always_comb begin
      en[NumStages-1] = !vld_ff[NumStages-1] || rsp_ready;
      for (int k = NumStages - 2; k >= 0; k--) begin
         en[k] = !vld_ff[k] || en[k+1];
      end
   end

   assign req_ready = en[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         if (en[0]) begin
            vld_ff[0] <= req_valid;
         end
         for (int k = 1; k < NumStages; k++) begin
            if (en[k]) begin
               vld_ff[k] <= vld_ff[k-1];
            end
         end
      end
   end

   // Stage 0: edge vectors b - a, c - a and p - a.
   logic signed [EdgeW-1:0] e0_ff [3];
   logic signed [EdgeW-1:0] e1_ff [3];
   logic signed [EdgeW-1:0] e2_ff [3];
   logic signed [CoordW-1:0] pc [3];
   logic signed [CoordW-1:0] ac [3];
   logic signed [CoordW-1:0] bc [3];
   logic signed [CoordW-1:0] cc [3];

   assign pc = '{req_p_x, req_p_y, req_p_z};
   assign ac = '{req_a_x, req_a_y, req_a_z};
   assign bc = '{req_b_x, req_b_y, req_b_z};
   assign cc = '{req_c_x, req_c_y, req_c_z};

   always_ff @(posedge clock) begin
      if (en[0]) begin
         for (int k = 0; k < 3; k++) begin
            e0_ff[k] <= EdgeW'(bc[k]) - EdgeW'(ac[k]);
            e1_ff[k] <= EdgeW'(cc[k]) - EdgeW'(ac[k]);
            e2_ff[k] <= EdgeW'(pc[k]) - EdgeW'(ac[k]);
         end
      end
   end

   // Stage 1: the fifteen component products of the five dot products.
   logic signed [ProdW-1:0] m00_ff [3];
   logic signed [ProdW-1:0] m01_ff [3];
   logic signed [ProdW-1:0] m11_ff [3];
   logic signed [ProdW-1:0] m20_ff [3];
   logic signed [ProdW-1:0] m21_ff [3];

   always_ff @(posedge clock) begin
      if (en[1]) begin
         for (int k = 0; k < 3; k++) begin
            m00_ff[k] <= ProdW'(e0_ff[k] * e0_ff[k]);
            m01_ff[k] <= ProdW'(e0_ff[k] * e1_ff[k]);
            m11_ff[k] <= ProdW'(e1_ff[k] * e1_ff[k]);
            m20_ff[k] <= ProdW'(e2_ff[k] * e0_ff[k]);
            m21_ff[k] <= ProdW'(e2_ff[k] * e1_ff[k]);
         end
      end
   end

   // Stage 2: dot products, exact.
   logic signed [DotW-1:0] d00_ff, d01_ff, d11_ff, d20_ff, d21_ff;

   function automatic logic signed [DotW-1:0] sum3(input logic signed [ProdW-1:0] m [3]);
      return DotW'(m[0]) + DotW'(m[1]) + DotW'(m[2]);
   endfunction

   always_ff @(posedge clock) begin
      if (en[2]) begin
         d00_ff <= sum3(m00_ff);
         d01_ff <= sum3(m01_ff);
         d11_ff <= sum3(m11_ff);
         d20_ff <= sum3(m20_ff);
         d21_ff <= sum3(m21_ff);
      end
   end

   // Stage 3: the six wide products of the Cramer terms.
   logic signed [WideW-1:0] pd0_ff, pd1_ff, pv0_ff, pv1_ff, pw0_ff, pw1_ff;

   always_ff @(posedge clock) begin
      if (en[3]) begin
         pd0_ff <= WideW'(d00_ff * d11_ff);
         pd1_ff <= WideW'(d01_ff * d01_ff);
         pv0_ff <= WideW'(d11_ff * d20_ff);
         pv1_ff <= WideW'(d01_ff * d21_ff);
         pw0_ff <= WideW'(d00_ff * d21_ff);
         pw1_ff <= WideW'(d01_ff * d20_ff);
      end
   end

   // Stage 4: determinant and the two numerators.
   logic signed [WideW-1:0] den_ff, nv_ff, nw_ff;

   always_ff @(posedge clock) begin
      if (en[4]) begin
         den_ff <= pd0_ff - pd1_ff;
         nv_ff  <= pv0_ff - pv1_ff;
         nw_ff  <= pw0_ff - pw1_ff;
      end
   end

   // Stage 5: numerator magnitudes and signs. The determinant is never
   // negative, so its low bits are its magnitude.
   logic [RemW-1:0] magv_ff, magw_ff;
   logic            negv_ff, negw_ff;
   logic [DenW-1:0] den5_ff;
   logic            degen5_ff;

   always_ff @(posedge clock) begin
      if (en[5]) begin
         negv_ff   <= nv_ff[WideW-1];
         negw_ff   <= nw_ff[WideW-1];
         magv_ff   <= nv_ff[WideW-1] ? RemW'(-nv_ff) : RemW'(nv_ff);
         magw_ff   <= nw_ff[WideW-1] ? RemW'(-nw_ff) : RemW'(nw_ff);
         den5_ff   <= den_ff[DenW-1:0];
         degen5_ff <= (den_ff == '0);
      end
   end

   // Stage 6: the dividend is the magnitude shifted up by sixteen. Its part
   // above the quotient width must stay below the divisor, or the quotient
   // does not fit in 32 bits and the weight saturates.
   div_word_type div_ff [DivSteps+1];

   function automatic div_lane_type lane_init(input logic [RemW-1:0] mag, input logic neg,
                                              input logic [DenW-1:0] den);
      div_lane_type l;
      l.rem = RemW'(mag[RemW-1:FracW]);
      l.sh  = {mag[FracW-1:0], {(QuotW-FracW){1'b0}}};
      l.ovf = (RemW'(mag[RemW-1:FracW]) >= RemW'(den));
      l.neg = neg;
      return l;
   endfunction

   always_ff @(posedge clock) begin
      if (en[6]) begin
         div_ff[0].lane_v <= lane_init(magv_ff, negv_ff, den5_ff);
         div_ff[0].lane_w <= lane_init(magw_ff, negw_ff, den5_ff);
         div_ff[0].den    <= den5_ff;
         div_ff[0].degen  <= degen5_ff;
      end
   end

   // Stages 7 to 38: one restoring-division step per stage for both lanes.
   for (genvar i = 0; i < DivSteps; i++) begin : g_div
      tbc_div_stage u_step (
         .clock (clock),
         .en    (en[FrontStages + i]),
         .d_in  (div_ff[i]),
         .d_ff  (div_ff[i+1])
      );
   end

   // Stage 39: apply the sign and saturate v and w, or zero them when degenerate.
   function automatic logic signed [QuotW-1:0] finish(input div_lane_type l);
      logic signed [QuotW-1:0] r;
      if (l.ovf) begin
         r = l.neg ? WeightMin : WeightMax;
      end else if (l.neg) begin
         r = (l.sh > QuotW'(WeightMin)) ? WeightMin : -$signed(l.sh);
      end else begin
         r = l.sh[QuotW-1] ? WeightMax : $signed(l.sh);
      end
      return r;
   endfunction

   logic signed [QuotW-1:0] v_ff, w_ff;
   logic                    degen_ff;
   localparam int FinStage = FrontStages + DivSteps;

   always_ff @(posedge clock) begin
      if (en[FinStage]) begin
         v_ff     <= div_ff[DivSteps].degen ? '0 : finish(div_ff[DivSteps].lane_v);
         w_ff     <= div_ff[DivSteps].degen ? '0 : finish(div_ff[DivSteps].lane_w);
         degen_ff <= div_ff[DivSteps].degen;
      end
   end

   // Stage 40: output register; u = 1 - v - w, saturated.
   logic signed [QuotW+1:0] u_sum;
   logic signed [QuotW-1:0] u_sat;

   always_comb begin
      u_sum = WeightOne - (QuotW+2)'(v_ff) - (QuotW+2)'(w_ff);
      if (u_sum > (QuotW+2)'(WeightMax)) begin
         u_sat = WeightMax;
      end else if (u_sum < (QuotW+2)'(WeightMin)) begin
         u_sat = WeightMin;
      end else begin
         u_sat = u_sum[QuotW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en[NumStages-1]) begin
         rsp_weight_u   <= degen_ff ? '0 : u_sat;
         rsp_weight_v   <= v_ff;
         rsp_weight_w   <= w_ff;
         rsp_degenerate <= degen_ff;
      end
   end

   assign rsp_valid = vld_ff[NumStages-1];

endmodule

// ----- design/tbc_checker.sv -----
module tbc_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic signed [31:0] rsp_weight_u,
   input logic signed [31:0] rsp_weight_v,
   input logic signed [31:0] rsp_weight_w,
   input logic               rsp_degenerate
);

   // A degenerate triangle gives all-zero weights.
   a_degen_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_degenerate |->
         rsp_weight_u == 0 && rsp_weight_v == 0 && rsp_weight_w == 0)
      else $error("degenerate word with nonzero weight");

   // The input side only backs up when a finished word is held at the output.
   a_ready_stall: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && !rsp_ready)
      else $error("input stalled while output drains");

   // The pipeline is empty right after reset.
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result word right after reset");

   // A held result word does not change.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      $past(rsp_valid && !rsp_ready) |->
         rsp_valid && $stable(rsp_weight_u) && $stable(rsp_weight_v) &&
         $stable(rsp_weight_w) && $stable(rsp_degenerate))
      else $error("stalled result word changed");

endmodule

bind triangle_barycentric_coords tbc_checker u_tbc_checker (
   .clock          (clock),
   .reset          (reset),
   .req_ready      (req_ready),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_weight_u   (rsp_weight_u),
   .rsp_weight_v   (rsp_weight_v),
   .rsp_weight_w   (rsp_weight_w),
   .rsp_degenerate (rsp_degenerate)
);

// ----- tb/sv/tb_top.sv -----
module tb_top;
   import tbc_pkg::*;

   // One expected result word, kept in arrival order of the request words.
   typedef struct {
      logic signed [31:0] u;
      logic signed [31:0] v;
      logic signed [31:0] w;
      logic               degen;
   } weights_type;

   typedef logic signed [15:0] coord_set_type [12];

   localparam int CycleLimit = 400000;
   localparam int DrainCycles = 60;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic signed [15:0] req_p_x = '0, req_p_y = '0, req_p_z = '0;
   logic signed [15:0] req_a_x = '0, req_a_y = '0, req_a_z = '0;
   logic signed [15:0] req_b_x = '0, req_b_y = '0, req_b_z = '0;
   logic signed [15:0] req_c_x = '0, req_c_y = '0, req_c_z = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic signed [31:0] rsp_weight_u, rsp_weight_v, rsp_weight_w;
   logic rsp_degenerate;

   weights_type pending_weights[$];
   int mismatches = 0;
   int cycle_count = 0;
   int send_idle_pct = 0;
   int recv_stall_pct = 0;

   triangle_barycentric_coords dut (.*);

   initial begin
      forever #5 clock = ~clock;
   end

   // The run is bounded so that a hung handshake cannot stall it forever.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CycleLimit) begin
         $display("tb_top: done, errors");
         $finish;
      end
   end

   // Rounded-toward-zero quotient of num * 2^16 by a positive den, saturated
   // to the Q15.16 range.
   function automatic logic signed [31:0] q16_quot(logic signed [127:0] num,
                                                   logic signed [127:0] den);
      logic         neg;
      logic [127:0] mag;
      logic [127:0] q;
      neg = num[127];
      mag = neg ? -num : num;
      q = (mag << 16) / den;
      if (neg) begin
         if (q > 128'h8000_0000) return WeightMin;
         return -q[31:0];
      end
      if (q > 128'h7FFF_FFFF) return WeightMax;
      return q[31:0];
   endfunction

   // Predicts the weights of point p against triangle a, b, c. The order of
   // the coordinate set is p, a, b, c, each as x, y, z.
   function automatic weights_type predict_weights(coord_set_type cs);
      weights_type r;
      logic signed [16:0] e0 [3], e1 [3], e2 [3];
      logic signed [127:0] d00, d01, d11, d20, d21, den, nv, nw;
      logic signed [63:0] usum;
      d00 = 0; d01 = 0; d11 = 0; d20 = 0; d21 = 0;
      for (int k = 0; k < 3; k++) begin
         e0[k] = 17'(cs[6+k]) - 17'(cs[3+k]);
         e1[k] = 17'(cs[9+k]) - 17'(cs[3+k]);
         e2[k] = 17'(cs[k])   - 17'(cs[3+k]);
         d00 += 128'(e0[k]) * 128'(e0[k]);
         d01 += 128'(e0[k]) * 128'(e1[k]);
         d11 += 128'(e1[k]) * 128'(e1[k]);
         d20 += 128'(e2[k]) * 128'(e0[k]);
         d21 += 128'(e2[k]) * 128'(e1[k]);
      end
      den = d00 * d11 - d01 * d01;
      if (den == 0) begin
         r.u = '0; r.v = '0; r.w = '0; r.degen = 1'b1;
         return r;
      end
      nv = d11 * d20 - d01 * d21;
      nw = d00 * d21 - d01 * d20;
      r.v = q16_quot(nv, den);
      r.w = q16_quot(nw, den);
      usum = 64'sd65536 - 64'(r.v) - 64'(r.w);
      if (usum > 64'(WeightMax)) r.u = WeightMax;
      else if (usum < 64'(WeightMin)) r.u = WeightMin;
      else r.u = usum[31:0];
      r.degen = 1'b0;
      return r;
   endfunction

   // Every accepted request word is predicted from the values on the ports.
   always @(posedge clock) begin
      coord_set_type cs;
      if (!reset && req_valid && req_ready) begin
         cs = '{req_p_x, req_p_y, req_p_z, req_a_x, req_a_y, req_a_z,
                req_b_x, req_b_y, req_b_z, req_c_x, req_c_y, req_c_z};
         pending_weights.push_back(predict_weights(cs));
      end
   end

   // The receiver stalls at the rate of the current phase.
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // Each result word is checked against the oldest prediction.
   always @(posedge clock) begin
      weights_type exp_w;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_weights.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result word: u=%0d v=%0d w=%0d degen=%0b",
                        rsp_weight_u, rsp_weight_v, rsp_weight_w, rsp_degenerate);
         end else begin
            exp_w = pending_weights.pop_front();
            if (rsp_weight_u !== exp_w.u || rsp_weight_v !== exp_w.v ||
                rsp_weight_w !== exp_w.w || rsp_degenerate !== exp_w.degen) begin
               mismatches++;
               if (mismatches <= 10)
                  $display({"weight mismatch: exp u=%0d v=%0d w=%0d degen=%0b, ",
                            "got u=%0d v=%0d w=%0d degen=%0b"},
                           exp_w.u, exp_w.v, exp_w.w, exp_w.degen, rsp_weight_u,
                           rsp_weight_v, rsp_weight_w, rsp_degenerate);
            end
         end
      end
   end

   // Sends one request word. Called at a rising edge and returns at the edge
   // where the word is taken. The ready line is looked at on the falling edge,
   // where it is stable, so the decision does not race the block.
   task automatic send_word(coord_set_type cs);
      logic fire;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      {req_p_x, req_p_y, req_p_z} <= {cs[0], cs[1], cs[2]};
      {req_a_x, req_a_y, req_a_z} <= {cs[3], cs[4], cs[5]};
      {req_b_x, req_b_y, req_b_z} <= {cs[6], cs[7], cs[8]};
      {req_c_x, req_c_y, req_c_z} <= {cs[9], cs[10], cs[11]};
      req_valid <= 1'b1;
      do begin
         @(negedge clock);
         fire = req_ready;
         @(posedge clock);
      end while (!fire);
   endtask

   // Holds the sender off until every predicted result has come back.
   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_weights.size() != 0) @(posedge clock);
   endtask

   function automatic logic signed [15:0] rand_coord(int mode);
      case (mode)
         0: return 16'($urandom());
         1: return 16'($urandom_range(511) - 256);
         default: return $urandom_range(1) ? 16'(16'sh7FFF - $urandom_range(3))
                                           : 16'(16'sh8000 + $urandom_range(3));
      endcase
   endfunction

   // Extreme coordinates in all fields and both signs.
   task automatic test_corners();
      coord_set_type cs;
      cs = '{default: 16'sh7FFF}; send_word(cs);
      cs = '{default: 16'sh8000}; send_word(cs);
      cs = '{default: 16'sh0000}; send_word(cs);
      cs = '{16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh8000, 16'sh8000, 16'sh8000,
             16'sh7FFF, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh7FFF, 16'sh8000};
      send_word(cs);
      cs = '{16'sh8000, 16'sh8000, 16'sh8000, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF,
             16'sh8000, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh8000, 16'sh7FFF};
      send_word(cs);
      // Unit right triangle with p on each vertex and far above its centroid.
      for (int k = 0; k < 4; k++) begin
         cs = '{default: 16'sh0000};
         cs[6] = 16'sh0100; cs[10] = 16'sh0100;
         if (k == 1) cs[0] = 16'sh0100;
         if (k == 2) cs[1] = 16'sh0100;
         if (k == 3) begin cs[0] = 16'sh0055; cs[1] = 16'sh0055; cs[2] = 16'sh7FFF; end
         send_word(cs);
      end
      // Tiny triangle with a far point: both quotients saturate.
      cs = '{16'sh7FFF, 16'sh7FFF, 16'sh0000, 16'sh8000, 16'sh8000, 16'sh0000,
             16'sh8001, 16'sh8000, 16'sh0000, 16'sh8000, 16'sh8001, 16'sh0000};
      send_word(cs);
      cs = '{16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh7FFF,
             16'sh7FFE, 16'sh8000, 16'sh7FFF, 16'sh7FFF, 16'sh8001, 16'sh7FFF};
      send_word(cs);
   endtask

   // Triangles of zero area: repeated vertices and collinear vertices.
   task automatic test_degenerate();
      coord_set_type cs;
      for (int k = 0; k < 6; k++) begin
         for (int i = 0; i < 12; i++) cs[i] = rand_coord(k % 3);
         case (k % 3)
            0: for (int i = 0; i < 3; i++) cs[6+i] = cs[3+i];
            1: for (int i = 0; i < 3; i++) cs[9+i] = cs[6+i];
            default: for (int i = 0; i < 3; i++) begin
               cs[3+i] = 16'($urandom_range(200) - 100);
               cs[6+i] = cs[3+i] + 16'(i + 1);
               cs[9+i] = cs[3+i] + 16'(3 * (i + 1));
            end
         endcase
         send_word(cs);
      end
   endtask

   // Random words: full-range, small-magnitude, near-extreme and collinear.
   task automatic test_random(int count);
      coord_set_type cs;
      int mode;
      int step;
      for (int n = 0; n < count; n++) begin
         mode = $urandom_range(9);
         for (int i = 0; i < 12; i++) cs[i] = rand_coord(mode < 5 ? 0 : mode < 8 ? 1 : 2);
         if (mode == 9) begin
            step = $urandom_range(4) - 2;
            for (int i = 0; i < 3; i++) cs[9+i] = cs[3+i] + 16'(step) * (cs[6+i] - cs[3+i]);
         end
         send_word(cs);
      end
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_corners();
      test_degenerate();
      drain_results();
      send_idle_pct = 12; recv_stall_pct = 82;
      test_random(150);
      drain_results();
      send_idle_pct = 82; recv_stall_pct = 12;
      test_random(150);
      send_idle_pct = 0; recv_stall_pct = 0;
      test_random(150);
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_weights.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
      if (mismatches == 0 && pending_weights.size() == 0) begin
         $display("tb_top: done, clean");
      end else begin
         $display("tb_top: done, errors");
      end
      $finish;
   end

endmodule
